// ----- rtl/pap_pkg.sv -----
package pap_pkg;

    typedef enum logic [1:0] {
        ACT_SEED   = 2'd0,
        ACT_ATTACH = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [9:0]  node;
        logic [9:0]  draw;
        logic        last;
    } t_req;

    typedef struct packed {
        logic [9:0]  target;
        logic        found;
        logic        fell_back;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SC_RD,
        S_SC_EV,
        S_SC_CMP,
        S_LK_RD,
        S_LK_WR,
        S_CM_RD,
        S_CM_ACC,
        S_DONE
    } t_state;

    localparam int unsigned SCALE   = 1000;
    localparam int unsigned DEG_W   = 10;
    localparam int unsigned DEG_MAX = 1023;
    localparam int unsigned TOT_W   = 21;
    localparam int unsigned NEED_W  = 31;
    localparam int unsigned PROD_W  = 20;
    localparam int unsigned CUM_W   = 33;

    // adder tree, six levels
    function automatic logic [6:0] f_popcount(input logic [63:0] w);
        logic [6:0] s [64];
        for (int i = 0; i < 64; i++) begin
            s[i] = 7'(w[i]);
        end
        for (int lvl = 0; lvl < 6; lvl++) begin
            for (int i = 0; i < (64 >> (lvl + 1)); i++) begin
                s[i] = s[2 * i] + s[2 * i + 1];
            end
        end
        return s[0];
    endfunction

endpackage

// ----- rtl/pap_chan_if.sv -----
interface pap_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pap_ram.sv -----
module pap_ram #(
    parameter int unsigned W     = 64,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/preferential_attachment_picker.sv -----
// Preferential-attachment graph builder.
// Request channel i_req (valid/ready) carries action, node, draw and last;
// response channel o_rsp carries target, found and fell_back, one response
// per request. Seed requests chain nodes into a ring, attach requests add
// one edge from a new node to a target chosen by cumulative degree, clear empties all.
// One request at a time: ready is high only while the sequencer is idle.
// Per request: an attach scan visits the nodes one at a time through the
// shared add/compare unit, each edge is a read-modify-write of two words
// of the adjacency memory (one read port, one write port), the degree
// commit on last reads every word of every adjacency row, and clear
// sweeps both memories; the result then goes to the response register.
// After reset a clearing pass sweeps the adjacency and degree memories;
// no request is taken meanwhile and no response is produced.
// The response register holds its result while the receiver stalls; a
// finished request waits for it to empty before the next one is taken.
module preferential_attachment_picker #(
    parameter int unsigned NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pap_chan_if.sink    i_req,
    pap_chan_if.source  o_rsp
);
    localparam int unsigned NW        = $clog2(NODES);
    localparam int unsigned ROW_WORDS = (NODES + 63) / 64;
    localparam int unsigned DEPTH     = NODES * ROW_WORDS;
    localparam int unsigned AW        = $clog2(DEPTH);
    localparam int unsigned WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int unsigned BW        = (NW < 6) ? NW : 6;
    localparam int unsigned DW        = $clog2(NODES + 1);

    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] row,
                                             input logic [AW-1:0] word);
        return AW'(AW'(row) * AW'(ROW_WORDS) + word);
    endfunction

    pap_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr;
    logic            r_emit;
    logic [NW-1:0]   r_node;
    logic            r_last;
    logic [NW-1:0]   r_k;
    logic [pap_pkg::CUM_W-1:0]  r_cum;
    logic [pap_pkg::NEED_W-1:0] r_need;
    logic [pap_pkg::PROD_W-1:0] r_prod;
    logic            r_elig;
    logic            r_have_fb;
    logic [NW-1:0]   r_fb;
    logic [NW-1:0]   r_tgt;
    logic            r_found;
    logic            r_fell;
    logic [NW-1:0]   r_la, r_lb;
    logic            r_half;
    logic            r_second;
    logic [NW-1:0]   r_row;
    logic [WW-1:0]   r_word;
    logic [DW-1:0]   r_dcnt;
    logic [pap_pkg::TOT_W-1:0] r_total;
    logic [NW-1:0]   r_first, r_prev;
    logic            r_started;
    logic            r_out_valid;
    pap_pkg::t_rsp   r_out;

    logic            adj_we;
    logic [AW-1:0]   adj_waddr, adj_raddr;
    logic [63:0]     adj_wdata, adj_q;
    logic            deg_we;
    logic [NW-1:0]   deg_waddr, deg_raddr;
    logic [pap_pkg::DEG_W-1:0] deg_wdata, deg_q;

    pap_ram #(.W(64), .DEPTH(DEPTH)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_q)
    );

    pap_ram #(.W(pap_pkg::DEG_W), .DEPTH(NODES)) u_deg (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_q)
    );

    // request decode
    logic          acc;
    logic          in_range;
    logic [NW-1:0] nidx;
    logic          link1, link2;

    assign acc      = i_req.valid && i_req.ready;
    assign in_range = 32'(i_req.payload.node) < NODES;
    assign nidx     = NW'(i_req.payload.node);
    assign link1    = r_started && (nidx != r_prev);
    assign link2    = r_started && i_req.payload.last && (nidx != r_first);

    // shared add and compare
    logic [pap_pkg::CUM_W-1:0] cum_nx;
    logic          hit;
    logic          fb_have_nx;
    logic [NW-1:0] fb_nx;
    logic          k_end;

    assign cum_nx     = r_cum + pap_pkg::CUM_W'(r_prod);
    assign hit        = r_elig && (cum_nx >= pap_pkg::CUM_W'(r_need));
    assign fb_have_nx = r_have_fb || r_elig;
    assign fb_nx      = r_have_fb ? r_fb : r_k;
    assign k_end      = (r_k == NW'(NODES - 1));

    // degree commit
    logic [6:0]                pc;
    logic [DW-1:0]             dsum;
    logic [pap_pkg::DEG_W-1:0] dsat;
    logic [pap_pkg::TOT_W:0]   tot_sum;
    logic [pap_pkg::TOT_W-1:0] tot_sat;
    logic                      word_end;
    logic                      row_end;

    assign pc       = pap_pkg::f_popcount(adj_q);
    assign dsum     = r_dcnt + DW'(pc);
    assign dsat     = (32'(dsum) > pap_pkg::DEG_MAX) ? pap_pkg::DEG_W'(pap_pkg::DEG_MAX)
                                                     : pap_pkg::DEG_W'(dsum);
    assign tot_sum  = ((r_row == '0) ? '0 : {1'b0, r_total})
                      + (pap_pkg::TOT_W + 1)'(dsat);
    assign tot_sat  = tot_sum[pap_pkg::TOT_W] ? '1 : tot_sum[pap_pkg::TOT_W-1:0];
    assign word_end = (r_word == WW'(ROW_WORDS - 1));
    assign row_end  = (r_row == NW'(NODES - 1));

    assign i_req.ready   = (r_state == pap_pkg::S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pap_pkg::S_CLR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = r_emit ? pap_pkg::S_DONE : pap_pkg::S_IDLE;
                end
            end
            pap_pkg::S_IDLE: begin
                if (acc) begin
                    case (i_req.payload.action)
                        pap_pkg::ACT_SEED: begin
                            if (!in_range) begin
                                n_state = pap_pkg::S_DONE;
                            end else if (link1 || link2) begin
                                n_state = pap_pkg::S_LK_RD;
                            end else if (i_req.payload.last) begin
                                n_state = pap_pkg::S_CM_RD;
                            end else begin
                                n_state = pap_pkg::S_DONE;
                            end
                        end
                        pap_pkg::ACT_ATTACH: begin
                            n_state = in_range ? pap_pkg::S_SC_RD : pap_pkg::S_DONE;
                        end
                        pap_pkg::ACT_CLEAR: n_state = pap_pkg::S_CLR;
                        default:            n_state = pap_pkg::S_DONE;
                    endcase
                end
            end
            pap_pkg::S_SC_RD: n_state = pap_pkg::S_SC_EV;
            pap_pkg::S_SC_EV: n_state = pap_pkg::S_SC_CMP;
            pap_pkg::S_SC_CMP: begin
                if (hit) begin
                    n_state = pap_pkg::S_LK_RD;
                end else if (k_end) begin
                    if (fb_have_nx) begin
                        n_state = pap_pkg::S_LK_RD;
                    end else if (r_last) begin
                        n_state = pap_pkg::S_CM_RD;
                    end else begin
                        n_state = pap_pkg::S_DONE;
                    end
                end else begin
                    n_state = pap_pkg::S_SC_RD;
                end
            end
            pap_pkg::S_LK_RD: n_state = pap_pkg::S_LK_WR;
            pap_pkg::S_LK_WR: begin
                if (!r_half || r_second) begin
                    n_state = pap_pkg::S_LK_RD;
                end else if (r_last) begin
                    n_state = pap_pkg::S_CM_RD;
                end else begin
                    n_state = pap_pkg::S_DONE;
                end
            end
            pap_pkg::S_CM_RD: n_state = pap_pkg::S_CM_ACC;
            pap_pkg::S_CM_ACC: begin
                n_state = (word_end && row_end) ? pap_pkg::S_DONE : pap_pkg::S_CM_RD;
            end
            pap_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = pap_pkg::S_IDLE;
                end
            end
            default: n_state = pap_pkg::S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = f_addr(r_la, AW'(r_lb >> 6));
        adj_wdata = adj_q | (64'd1 << r_lb[BW-1:0]);
        adj_raddr = '0;
        deg_we    = 1'b0;
        deg_waddr = r_row;
        deg_wdata = dsat;
        deg_raddr = r_k;
        case (r_state)
            pap_pkg::S_CLR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                adj_wdata = '0;
                deg_we    = (AW + 1)'(r_clr) < (AW + 1)'(NODES);
                deg_waddr = NW'(r_clr);
                deg_wdata = '0;
            end
            pap_pkg::S_SC_RD:  adj_raddr = f_addr(r_node, AW'(r_k >> 6));
            pap_pkg::S_LK_RD:  adj_raddr = f_addr(r_la, AW'(r_lb >> 6));
            pap_pkg::S_LK_WR:  adj_we = 1'b1;
            pap_pkg::S_CM_RD:  adj_raddr = f_addr(r_row, AW'(r_word));
            pap_pkg::S_CM_ACC: deg_we = word_end;
            default: begin
                adj_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pap_pkg::S_CLR;
            r_clr       <= '0;
            r_emit      <= 1'b0;
            r_total     <= '0;
            r_first     <= '0;
            r_prev      <= '0;
            r_started   <= 1'b0;
            r_half      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pap_pkg::S_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pap_pkg::S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                pap_pkg::S_IDLE: begin
                    if (acc) begin
                        r_tgt   <= '0;
                        r_found <= 1'b0;
                        r_fell  <= 1'b0;
                        r_last  <= i_req.payload.last;
                        r_node  <= nidx;
                        r_row   <= '0;
                        r_word  <= '0;
                        r_dcnt  <= '0;
                        r_half  <= 1'b0;
                        r_k       <= '0;
                        r_cum     <= '0;
                        r_have_fb <= 1'b0;
                        r_need    <= pap_pkg::NEED_W'(pap_pkg::NEED_W'(i_req.payload.draw)
                                     * pap_pkg::NEED_W'(r_total));
                        case (i_req.payload.action)
                            pap_pkg::ACT_SEED: begin
                                if (in_range) begin
                                    r_found <= link1 || link2;
                                    r_tgt   <= link2 ? r_first : (link1 ? r_prev : '0);
                                    if (link1) begin
                                        r_la     <= r_prev;
                                        r_lb     <= nidx;
                                        r_second <= link2;
                                    end else begin
                                        r_la     <= nidx;
                                        r_lb     <= r_first;
                                        r_second <= 1'b0;
                                    end
                                    r_prev <= nidx;
                                    if (!r_started) begin
                                        r_first <= nidx;
                                    end
                                    r_started <= !i_req.payload.last;
                                end
                            end
                            pap_pkg::ACT_CLEAR: begin
                                r_clr     <= '0;
                                r_emit    <= 1'b1;
                                r_total   <= '0;
                                r_first   <= '0;
                                r_prev    <= '0;
                                r_started <= 1'b0;
                            end
                            default: begin
                                r_second <= 1'b0;
                            end
                        endcase
                    end
                end
                pap_pkg::S_SC_EV: begin
                    r_prod <= pap_pkg::PROD_W'(deg_q) * pap_pkg::PROD_W'(pap_pkg::SCALE);
                    r_elig <= (deg_q != '0) && !adj_q[r_k[BW-1:0]];
                end
                pap_pkg::S_SC_CMP: begin
                    r_cum     <= cum_nx;
                    r_have_fb <= fb_have_nx;
                    r_fb      <= fb_nx;
                    r_k       <= r_k + 1'b1;
                    if (hit) begin
                        r_tgt   <= r_k;
                        r_found <= 1'b1;
                        r_la    <= r_node;
                        r_lb    <= r_k;
                    end else if (k_end && fb_have_nx) begin
                        r_tgt   <= fb_nx;
                        r_found <= 1'b1;
                        r_fell  <= 1'b1;
                        r_la    <= r_node;
                        r_lb    <= fb_nx;
                    end
                end
                pap_pkg::S_LK_WR: begin
                    if (!r_half) begin
                        r_half <= 1'b1;
                        r_la   <= r_lb;
                        r_lb   <= r_la;
                    end else begin
                        r_half <= 1'b0;
                        if (r_second) begin
                            r_second <= 1'b0;
                            r_la     <= r_node;
                            r_lb     <= r_first;
                        end
                    end
                end
                pap_pkg::S_CM_ACC: begin
                    if (word_end) begin
                        r_dcnt  <= '0;
                        r_word  <= '0;
                        r_total <= tot_sat;
                        r_row   <= r_row + 1'b1;
                    end else begin
                        r_dcnt <= dsum;
                        r_word <= r_word + 1'b1;
                    end
                end
                pap_pkg::S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out.target    <= 10'(r_tgt);
                        r_out.found     <= r_found;
                        r_out.fell_back <= r_fell;
                    end
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fell_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.fell_back) |-> o_rsp.payload.found)
        else $error("fell_back without found");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pap_pkg::S_CLR) |-> !i_req.ready)
        else $error("ready during clearing pass");

    a_target_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (32'(r_tgt) < NODES))
        else $error("target outside node range");
`endif

endmodule
